/* design/binarize_threshold_border_aware_top_defines.svh */
// Assertion macros shared by the binarizer RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BINARIZE_THRESHOLD_BORDER_AWARE_TOP_DEFINES_SVH
`define BINARIZE_THRESHOLD_BORDER_AWARE_TOP_DEFINES_SVH
`ifndef SYNTH
`define BTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BTA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BTA_ASSERT(lbl, prop, msg)
`define BTA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* design/bta_pkg.sv */
package bta_pkg;

  // Default sizes of the block
  localparam int CHANNELS_DEF = 64;
  localparam int LANES_DEF    = 32;
  localparam int MAX_DIM_DEF  = 1024;

  // Fixed field widths
  localparam int VAL_W     = 16;
  localparam int SEL_W     = 2;
  localparam int CHIDX_W   = 6;
  localparam int WORD_W    = 32;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Map dimensions after reset
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_ACT  = 1'b1
  } op_e;

  typedef enum logic [SEL_W-1:0] {
    TBL_INTERIOR = 2'd0,
    TBL_EDGE     = 2'd1,
    TBL_CORNER   = 2'd2
  } tbl_sel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1
  } cfg_reg_e;

endpackage

/* design/bta_if.sv */
// Input channel: threshold loads and activation samples
interface bta_in_if import bta_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [SEL_W-1:0]   table_sel;
  logic [CHIDX_W-1:0] chan_index;
  logic [VAL_W-1:0]   value;

  modport source (output valid, op, table_sel, chan_index, value, input ready);
  modport sink   (input valid, op, table_sel, chan_index, value, output ready);
endinterface

// Output channel: packed comparison words
interface bta_out_if import bta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_bits;
  logic              group;
  logic              pixel_done;

  modport source (output valid, packed_bits, group, pixel_done, input ready);
  modport sink   (input valid, packed_bits, group, pixel_done, output ready);
endinterface

// Configuration write channel
interface bta_cfg_if import bta_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/binarize_threshold_border_aware_top.sv */
// Border-aware threshold binarizer. Takes one word per cycle on in_i: a load
// word (op 0) writes a 16-bit threshold into the interior, edge or corner
// table for one channel; an activation word (op 1) is doubled (top bit
// dropped) and compared, greater or equal, with the threshold of its pixel's
// border class and channel. Activations arrive in raster order, channel
// fastest. Comparison bits are packed LANES to a word (lane i at bit i) and
// one word leaves on out_o per channel group, with pixel_done on the last
// group of each pixel. The thresholds live in a single RAM with one read and
// one write port; each item makes at most one access, so the rate above holds
// while in_i.ready is high. A result word passes the compare stage and the
// output register to out_o. in_i.ready drops only while a finished word sits
// unclaimed in the output register and the next one is ready behind it.
// Thresholds must be loaded before they are used; there is no clearing pass
// after reset. Write map_width and map_height only while the block is idle.
`include "binarize_threshold_border_aware_top_defines.svh"

module binarize_threshold_border_aware_top import bta_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int LANES    = LANES_DEF,
  parameter int MAX_DIM  = MAX_DIM_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bta_cfg_if.sink  cfg_i,
  bta_in_if.sink   in_i,
  bta_out_if.source out_o
);

  localparam int CH_W   = $clog2(CHANNELS);
  localparam int LN_W   = $clog2(LANES);
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int EW_RAW = $clog2(MAX_DIM + 1);
  localparam int EW     = (EW_RAW > DIM_W) ? EW_RAW : DIM_W;
  localparam int DEPTH  = 3 * CHANNELS;
  localparam int AW     = $clog2(DEPTH);

  localparam logic [AW-1:0]    EDGE_BASE   = AW'(CHANNELS);
  localparam logic [AW-1:0]    CORNER_BASE = AW'(2 * CHANNELS);
  localparam logic [CH_W-1:0]  CH_LAST     = CH_W'(CHANNELS - 1);
  localparam logic [LN_W-1:0]  LANE_LAST   = LN_W'(LANES - 1);
  localparam logic [EW-1:0]    DIM_MAX     = EW'(MAX_DIM);
  localparam logic             GRP_LAST    = 1'(((CHANNELS - 1) / LANES) % 2);

  // Configuration registers
  logic [DIM_W-1:0] map_w_q, map_w_d;
  logic [DIM_W-1:0] map_h_q, map_h_d;

  // Position counters
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [CH_W-1:0]  chan_q, chan_d;
  logic [LN_W-1:0]  lane_q, lane_d;
  logic             grp_q, grp_d;

  // Compare stage
  logic             s1_valid_q, s1_valid_d;
  logic [VAL_W-1:0] s1_act_q, s1_act_d;
  logic [LN_W-1:0]  s1_lane_q, s1_lane_d;
  logic             s1_grp_q, s1_grp_d;
  logic             s1_last_q, s1_last_d;
  logic             s1_emit_q, s1_emit_d;
  logic [WORD_W-1:0] accum_q, accum_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_bits_q, out_bits_d;
  logic              out_grp_q, out_grp_d;
  logic              out_done_q, out_done_d;

  // Datapath signals
  logic [EW-1:0]     w_ext, h_ext, eff_w, eff_h;
  logic              on_col, on_row, col_wrap, row_wrap;
  tbl_sel_e          cls;
  logic [AW-1:0]     rd_base, rd_addr, wr_base, wr_addr;
  logic              wr_sel_ok, ch_ok;
  logic              in_acc, act_acc, ram_we, in_ready;
  logic              chan_last, lane_last;
  logic [VAL_W-1:0]  thr;
  logic              hit, s1_go;
  logic [WORD_W-1:0] lane_bit, word;

  assign cfg_i.ready = 1'b1;

  // Take configuration writes
  always_comb begin
    map_w_d = map_w_q;
    map_h_d = map_h_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MAP_WIDTH:  map_w_d = cfg_i.data;
        REG_MAP_HEIGHT: map_h_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  // Clamp dimensions: zero acts as one, oversize saturates
  always_comb begin
    w_ext = EW'(map_w_q);
    h_ext = EW'(map_h_q);
    eff_w = (w_ext == '0) ? EW'(1) : ((w_ext > DIM_MAX) ? DIM_MAX : w_ext);
    eff_h = (h_ext == '0) ? EW'(1) : ((h_ext > DIM_MAX) ? DIM_MAX : h_ext);
  end

  // Classify the current pixel
  always_comb begin
    on_col   = (col_q == '0) || (EW'(col_q) == eff_w - EW'(1));
    on_row   = (row_q == '0) || (EW'(row_q) == eff_h - EW'(1));
    col_wrap = (EW'(col_q) + EW'(1)) >= eff_w;
    row_wrap = (EW'(row_q) + EW'(1)) >= eff_h;
    if (on_col && on_row) begin
      cls = TBL_CORNER;
    end else if (on_col || on_row) begin
      cls = TBL_EDGE;
    end else begin
      cls = TBL_INTERIOR;
    end
  end

  // Threshold addresses for read and load
  always_comb begin
    case (cls)
      TBL_EDGE:   rd_base = EDGE_BASE;
      TBL_CORNER: rd_base = CORNER_BASE;
      default:    rd_base = '0;
    endcase
    rd_addr = rd_base + AW'(chan_q);

    wr_sel_ok = 1'b1;
    case (in_i.table_sel)
      TBL_INTERIOR: wr_base = '0;
      TBL_EDGE:     wr_base = EDGE_BASE;
      TBL_CORNER:   wr_base = CORNER_BASE;
      default: begin
        wr_base   = '0;
        wr_sel_ok = 1'b0;
      end
    endcase
    ch_ok   = 32'(in_i.chan_index) < 32'(CHANNELS);
    wr_addr = wr_base + AW'(in_i.chan_index);
  end

  // Handshake and stage control
  always_comb begin
    s1_go     = s1_valid_q && (!s1_emit_q || !out_valid_q || out_o.ready);
    in_ready  = !s1_valid_q || s1_go;
    in_acc    = in_i.valid && in_ready;
    act_acc   = in_acc && (in_i.op == OP_ACT);
    ram_we    = in_acc && (in_i.op == OP_LOAD) && wr_sel_ok && ch_ok;
    chan_last = chan_q == CH_LAST;
    lane_last = lane_q == LANE_LAST;
  end

  assign in_i.ready = in_ready;

  bta_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (in_i.value),
    .re_i    (act_acc),
    .raddr_i (rd_addr),
    .rdata_o (thr)
  );

  // Advance counters and load the compare stage
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    chan_d = chan_q;
    lane_d = lane_q;
    grp_d  = grp_q;
    s1_act_d  = s1_act_q;
    s1_lane_d = s1_lane_q;
    s1_grp_d  = s1_grp_q;
    s1_last_d = s1_last_q;
    s1_emit_d = s1_emit_q;
    s1_valid_d = s1_go ? 1'b0 : s1_valid_q;
    if (act_acc) begin
      s1_valid_d = 1'b1;
      s1_act_d   = {in_i.value[VAL_W-2:0], 1'b0};
      s1_lane_d  = lane_q;
      s1_grp_d   = grp_q;
      s1_last_d  = chan_last;
      s1_emit_d  = chan_last || lane_last;
      if (chan_last) begin
        chan_d = '0;
        lane_d = '0;
        grp_d  = 1'b0;
        if (col_wrap) begin
          col_d = '0;
          row_d = row_wrap ? '0 : row_q + CNT_W'(1);
        end else begin
          col_d = col_q + CNT_W'(1);
        end
      end else begin
        chan_d = chan_q + CH_W'(1);
        lane_d = lane_last ? '0 : lane_q + LN_W'(1);
        grp_d  = grp_q ^ lane_last;
      end
    end
  end

  // Compare, pack and hand the word to the output register
  always_comb begin
    hit      = s1_act_q >= thr;
    lane_bit = (32'(s1_lane_q) < WORD_W) ? (WORD_W'(1) << s1_lane_q) : '0;
    word     = accum_q | (hit ? lane_bit : '0);
    accum_d     = accum_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_bits_d  = out_bits_q;
    out_grp_d   = out_grp_q;
    out_done_d  = out_done_q;
    if (s1_go) begin
      if (s1_emit_q) begin
        accum_d     = '0;
        out_valid_d = 1'b1;
        out_bits_d  = word;
        out_grp_d   = s1_grp_q;
        out_done_d  = s1_last_q;
      end else begin
        accum_d = word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q     <= DIM_RESET;
      map_h_q     <= DIM_RESET;
      col_q       <= '0;
      row_q       <= '0;
      chan_q      <= '0;
      lane_q      <= '0;
      grp_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      map_w_q     <= map_w_d;
      map_h_q     <= map_h_d;
      col_q       <= col_d;
      row_q       <= row_d;
      chan_q      <= chan_d;
      lane_q      <= lane_d;
      grp_q       <= grp_d;
      s1_valid_q  <= s1_valid_d;
      accum_q     <= accum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s1_act_q   <= s1_act_d;
    s1_lane_q  <= s1_lane_d;
    s1_grp_q   <= s1_grp_d;
    s1_last_q  <= s1_last_d;
    s1_emit_q  <= s1_emit_d;
    out_bits_q <= out_bits_d;
    out_grp_q  <= out_grp_d;
    out_done_q <= out_done_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.packed_bits = out_bits_q;
  assign out_o.group       = out_grp_q;
  assign out_o.pixel_done  = out_done_q;

  `BTA_ASSERT(a_act_enters_stage, (act_acc |=> s1_valid_q), "accepted activation lost")
  `BTA_ASSERT(a_done_group, ((out_o.valid && out_o.pixel_done) |-> (out_o.group == GRP_LAST)), "pixel_done on wrong group")
  `BTA_ASSERT(a_pixel_start_clean, ((chan_q == '0) |-> (lane_q == '0 && !grp_q)), "lane or group not cleared at pixel start")
  `BTA_ASSERT_NEVER(a_ram_one_access, (ram_we && act_acc), "RAM read and write in one cycle")

endmodule

/* design/bta_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read data
module bta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
